/* sv/dcsg_pkg.sv */
package dcsg_pkg;

  // Coordinates on the ports and in the configuration registers.
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DEPTH_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_END_X   = 3'd2,
    REG_END_Y   = 3'd3,
    REG_DEPTH   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_DESCEND
  } dcsg_state_e;

  typedef struct packed {
    logic restart;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_x0;
    logic signed [COORD_W-1:0] seg_y0;
    logic signed [COORD_W-1:0] seg_x1;
    logic signed [COORD_W-1:0] seg_y1;
    logic                      last_segment;
  } seg_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

endpackage

/* sv/dcsg_intf.sv */
interface dcsg_req_if;
  logic          valid;
  logic          ready;
  dcsg_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcsg_seg_if;
  logic          valid;
  logic          ready;
  dcsg_pkg::seg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcsg_cfg_if;
  logic          valid;
  logic          ready;
  dcsg_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/dcsg_stack.sv */
module dcsg_stack #(
  parameter int unsigned WIDTH = 37,
  parameter int unsigned DEPTH = 17
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/dragon_curve_segment_generator.sv */
// Dragon curve segment generator. Each request returns the next of the 2^depth segments of
// the curve drawn between the start and end points, with last_segment set on the final one;
// a request with restart set, or any request once a curve has finished, begins the curve
// again from the configured points and depth (above MAX_DEPTH it saturates). A request descends
// through the subdivision levels it still has, pushing a pending point at each level, and then
// delivers one segment. The pending point stack is a single memory that takes one push per
// cycle while the walk descends; the top entry is read back as each segment is delivered, so a
// pop needs no separate read step. Registers may be written between requests; they are sampled
// when a curve begins.
module dragon_curve_segment_generator #(
  parameter int unsigned MAX_DEPTH  = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  dcsg_req_if.sink        req_i,
  dcsg_seg_if.source      seg_o,
  dcsg_cfg_if.sink        cfg_i
);

  localparam int unsigned CAP     = MAX_DEPTH + 1;
  localparam int unsigned IDX_W   = $clog2(CAP);
  localparam int unsigned SP_W    = $clog2(CAP + 1);
  localparam int unsigned LVL_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ENTRY_W = 2 * COORD_BITS + LVL_W;
  localparam int unsigned W       = COORD_BITS;
  localparam int unsigned CW      = dcsg_pkg::COORD_W;

  // Halving with truncation toward zero of a (W+1)-bit signed value.
  function automatic logic signed [W-1:0] halve(input logic signed [W:0] s);
    logic signed [W:0] t;
    t = s + {{W{1'b0}}, s[W]};
    return t[W:1];
  endfunction

  // Configuration registers
  logic signed [CW-1:0]               start_x_q, start_y_q, end_x_q, end_y_q;
  logic [dcsg_pkg::DEPTH_W-1:0]       depth_q;

  // Walk state
  dcsg_pkg::dcsg_state_e state_q, state_d;
  logic [SP_W-1:0]       sp_q, sp_d;
  logic signed [W-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [W-1:0]   px_q, px_d, py_q, py_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;

  // Output register
  logic           out_valid_q, out_valid_d;
  dcsg_pkg::seg_t out_q, out_d;
  logic           out_load;

  // Stack memory ports
  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  logic [SP_W-1:0]    sp_dec;

  logic [LVL_W-1:0]    depth_sat;
  logic signed [W-1:0] fold_m, fold_u;
  logic                req_fire;

  dcsg_stack #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAP)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= 16'sd200;
      start_y_q <= 16'sd600;
      end_x_q   <= 16'sd600;
      end_y_q   <= 16'sd600;
      depth_q   <= 5'd10;
    end else if (cfg_i.valid) begin
      case (dcsg_pkg::cfg_reg_e'(cfg_i.data.index))
        dcsg_pkg::REG_START_X: start_x_q <= cfg_i.data.value;
        dcsg_pkg::REG_START_Y: start_y_q <= cfg_i.data.value;
        dcsg_pkg::REG_END_X:   end_x_q   <= cfg_i.data.value;
        dcsg_pkg::REG_END_Y:   end_y_q   <= cfg_i.data.value;
        dcsg_pkg::REG_DEPTH:   depth_q   <= cfg_i.data.value[dcsg_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign depth_sat = (depth_q > dcsg_pkg::DEPTH_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH)
                                                               : LVL_W'(depth_q);

  // Fold point of the segment from the current point to the pending end point.
  always_comb begin
    logic signed [W:0] sum_x, sum_y, dif_x, dif_y;
    sum_x  = {cur_x_q[W-1], cur_x_q} + {px_q[W-1], px_q};
    sum_y  = {cur_y_q[W-1], cur_y_q} + {py_q[W-1], py_q};
    dif_x  = {px_q[W-1], px_q} - {cur_x_q[W-1], cur_x_q};
    dif_y  = {py_q[W-1], py_q} - {cur_y_q[W-1], cur_y_q};
    fold_m = halve(sum_x) + halve(dif_y);
    fold_u = halve(sum_y) - halve(dif_x);
  end

  assign req_i.ready = (state_q == dcsg_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign sp_dec      = sp_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    px_d        = px_q;
    py_d        = py_q;
    lvl_d       = lvl_q;
    out_d       = out_q;
    out_load    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = sp_q[IDX_W-1:0];
    wr_data     = {px_q, py_q, lvl_q - 1'b1};
    rd_en       = 1'b0;
    rd_addr     = sp_dec[IDX_W-1:0];

    case (state_q)
      dcsg_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.data.restart || sp_q == '0) begin
            cur_x_d = W'(start_x_q);
            cur_y_d = W'(start_y_q);
            px_d    = W'(end_x_q);
            py_d    = W'(end_y_q);
            lvl_d   = depth_sat;
            sp_d    = '0;
          end else begin
            // The top entry was already read when the previous segment left.
            px_d  = rd_data[ENTRY_W-1 -: W];
            py_d  = rd_data[LVL_W +: W];
            lvl_d = rd_data[LVL_W-1:0];
            sp_d  = sp_dec;
          end
          state_d = dcsg_pkg::ST_DESCEND;
        end
      end
      dcsg_pkg::ST_DESCEND: begin
        if (lvl_q != '0) begin
          if (sp_q < SP_W'(CAP)) begin
            wr_en = 1'b1;
            sp_d  = sp_q + 1'b1;
          end
          px_d  = fold_m;
          py_d  = fold_u;
          lvl_d = lvl_q - 1'b1;
        end else if (!out_valid_q || seg_o.ready) begin
          out_load           = 1'b1;
          out_d.seg_x0       = CW'(cur_x_q);
          out_d.seg_y0       = CW'(cur_y_q);
          out_d.seg_x1       = CW'(px_q);
          out_d.seg_y1       = CW'(py_q);
          out_d.last_segment = (sp_q == '0);
          cur_x_d            = px_q;
          cur_y_d            = py_q;
          rd_en              = (sp_q != '0);
          state_d            = dcsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (seg_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcsg_pkg::ST_IDLE;
      sp_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    out_q <= out_d;
  end

  assign seg_o.valid = out_valid_q;
  assign seg_o.data  = out_q;

  // The stack pointer never passes the capacity of the stack.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(CAP))
    else $error("stack pointer beyond capacity");

  // A descent step always finds room, since the depth is saturated.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcsg_pkg::ST_DESCEND && lvl_q != '0) |-> sp_q < SP_W'(CAP))
    else $error("push into a full stack");

  // An accepted request always starts a descent in the next cycle.
  a_req_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == dcsg_pkg::ST_DESCEND)
    else $error("accepted request did not start a descent");

  // A delivered segment is flagged last exactly when the stack is empty.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && out_q.last_segment == (sp_q == '0)))
    else $error("last segment flag disagrees with stack");

endmodule

/* verif/dragon_curve_segment_generator_tb.sv */
`timescale 1ns / 1ps

module dragon_curve_segment_generator_tb;

  localparam int unsigned COORD_W    = dcsg_pkg::COORD_W;
  localparam int unsigned DEPTH_W    = dcsg_pkg::DEPTH_W;
  localparam int unsigned MAX_DEPTH  = 16;
  localparam int unsigned STACK_SIZE = MAX_DEPTH + 1;
  localparam int unsigned N_PHASES   = 16;
  localparam int unsigned PHASE_REQS = 88;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned CYCLE_CAP  = 500000;

  typedef enum logic {
    ROW_REG,
    ROW_REQ
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    dcsg_pkg::cfg_reg_e reg_idx;
    logic [COORD_W-1:0] value;
    logic               restart;
    logic               pinned;
    dcsg_pkg::seg_t     want;
  } stim_row_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        lvl;
  } pend_pt_t;

  logic clk_i;
  logic rst_ni;

  dcsg_req_if req_if ();
  dcsg_seg_if seg_if ();
  dcsg_cfg_if cfg_if ();

  dragon_curve_segment_generator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .seg_o  (seg_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the registers and of the walk, as they stand after reset.
  logic signed [COORD_W-1:0] base_x0 = 16'sd200;
  logic signed [COORD_W-1:0] base_y0 = 16'sd600;
  logic signed [COORD_W-1:0] base_x1 = 16'sd600;
  logic signed [COORD_W-1:0] base_y1 = 16'sd600;
  logic [DEPTH_W-1:0]        depth_reg = 5'd10;
  pend_pt_t                  fold_stack [STACK_SIZE];
  int                        walk_sp = 0;
  logic signed [COORD_W-1:0] pen_x = '0;
  logic signed [COORD_W-1:0] pen_y = '0;
  bit                        walking = 1'b0;

  dcsg_pkg::seg_t segs_due [$];
  stim_row_t      plan [$];
  bit             pin_active = 1'b0;
  dcsg_pkg::seg_t pin_seg = '0;
  bit             req_up = 1'b0;
  bit             cfg_up = 1'b0;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  int             mismatches = 0;
  int             segs_seen = 0;
  int             curves_done = 0;
  int             restarts_seen = 0;
  int             reqs_seen = 0;
  int             cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_pending(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic [DEPTH_W-1:0] lvl);
    if (walk_sp < STACK_SIZE) begin
      fold_stack[walk_sp] = '{x: x, y: y, lvl: lvl};
      walk_sp++;
    end
  endfunction

  // Pops the next pending end point and folds it down to level zero, leaving the
  // outer halves on the stack; the segment from the pen to that point is the answer.
  function automatic dcsg_pkg::seg_t next_fold_segment(input logic restart);
    dcsg_pkg::seg_t            s;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [DEPTH_W-1:0]        lvl;
    int                        m;
    int                        u;
    if (restart || !walking || walk_sp == 0) begin
      walk_sp = 0;
      pen_x = base_x0;
      pen_y = base_y0;
      push_pending(base_x1, base_y1,
                   (depth_reg > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : depth_reg);
      walking = 1'b1;
    end
    walk_sp--;
    px  = fold_stack[walk_sp].x;
    py  = fold_stack[walk_sp].y;
    lvl = fold_stack[walk_sp].lvl;
    while (lvl != 0) begin
      m = (int'(pen_x) + int'(px)) / 2 + (int'(py) - int'(pen_y)) / 2;
      u = (int'(pen_y) + int'(py)) / 2 - (int'(px) - int'(pen_x)) / 2;
      lvl--;
      push_pending(px, py, lvl);
      px = m[COORD_W-1:0];
      py = u[COORD_W-1:0];
    end
    s.seg_x0       = pen_x;
    s.seg_y0       = pen_y;
    s.seg_x1       = px;
    s.seg_y1       = py;
    s.last_segment = (walk_sp == 0);
    pen_x = px;
    pen_y = py;
    if (walk_sp == 0) walking = 1'b0;
    return s;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Registers, requests and segments are all observed in this one process, so the
  // order of the three within an edge is fixed.
  always @(posedge clk_i) begin
    dcsg_pkg::seg_t got;
    dcsg_pkg::seg_t due;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          dcsg_pkg::REG_START_X: base_x0 = cfg_if.data.value;
          dcsg_pkg::REG_START_Y: base_y0 = cfg_if.data.value;
          dcsg_pkg::REG_END_X:   base_x1 = cfg_if.data.value;
          dcsg_pkg::REG_END_Y:   base_y1 = cfg_if.data.value;
          dcsg_pkg::REG_DEPTH:   depth_reg = cfg_if.data.value[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        due = next_fold_segment(req_if.data.restart);
        if (pin_active) due = pin_seg;
        segs_due.push_back(due);
        reqs_seen++;
        if (req_if.data.restart) restarts_seen++;
      end
      if (seg_if.valid && seg_if.ready) begin
        got = seg_if.data;
        if (segs_due.size() == 0) begin
          $error("segment delivered with no request outstanding");
          mismatches++;
        end else begin
          due = segs_due.pop_front();
          check_field("seg_x0", int'($signed(due.seg_x0)), int'($signed(got.seg_x0)));
          check_field("seg_y0", int'($signed(due.seg_y0)), int'($signed(got.seg_y0)));
          check_field("seg_x1", int'($signed(due.seg_x1)), int'($signed(got.seg_x1)));
          check_field("seg_y1", int'($signed(due.seg_y1)), int'($signed(got.seg_y1)));
          check_field("last_segment", int'(due.last_segment), int'(got.last_segment));
          segs_seen++;
          if (got.last_segment) curves_done++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    seg_if.ready <= rst_ni && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $error("timed out with %0d segments still due", segs_due.size());
      $display("** dragon_curve_segment_generator: FAILED **");
      $finish;
    end
  end

  function automatic void plan_reg(input dcsg_pkg::cfg_reg_e idx,
                                   input logic [COORD_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.value   = value;
    plan.push_back(r);
  endfunction

  function automatic void plan_req(input logic restart);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_REQ;
    r.restart = restart;
    plan.push_back(r);
  endfunction

  function automatic void plan_pinned(input logic restart, input int x0, input int y0,
                                      input int x1, input int y1, input logic last);
    stim_row_t r;
    r = '0;
    r.kind              = ROW_REQ;
    r.restart           = restart;
    r.pinned            = 1'b1;
    r.want.seg_x0       = COORD_W'(x0);
    r.want.seg_y0       = COORD_W'(y0);
    r.want.seg_x1       = COORD_W'(x1);
    r.want.seg_y1       = COORD_W'(y1);
    r.want.last_segment = last;
    plan.push_back(r);
  endfunction

  task automatic issue_request(input logic restart, input logic pinned,
                               input dcsg_pkg::seg_t want);
    if (cfg_up) begin
      cfg_if.valid <= 1'b0;
      cfg_up = 1'b0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      if (req_up) begin
        req_if.valid <= 1'b0;
        req_up = 1'b0;
      end
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.data.restart <= restart;
    pin_active          <= pinned;
    pin_seg             <= want;
    req_up = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Registers are only written once every segment asked for has come back.
  task automatic write_reg(input dcsg_pkg::cfg_reg_e idx, input logic [COORD_W-1:0] value);
    // Let the monitor record a request accepted at this edge first.
    #1;
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (segs_due.size() != 0) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= value;
    cfg_up = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  initial begin : stimulus
    logic [COORD_W-1:0] value;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    seg_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A request while idle starts the reset curve; a restart mid-walk begins it again.
    plan_req(1'b0);
    plan_req(1'b0);
    plan_req(1'b1);
    plan_req(1'b0);
    // Depth zero returns the base segment itself, each time as the last one.
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd0);
    plan_pinned(1'b1, 200, 600, 600, 600, 1'b1);
    plan_pinned(1'b0, 200, 600, 600, 600, 1'b1);
    plan_pinned(1'b1, 200, 600, 600, 600, 1'b1);
    plan_reg(dcsg_pkg::REG_START_X, 16'h8000);
    plan_reg(dcsg_pkg::REG_START_Y, 16'h8000);
    plan_reg(dcsg_pkg::REG_END_X, 16'h7FFF);
    plan_reg(dcsg_pkg::REG_END_Y, 16'h7FFF);
    plan_pinned(1'b0, -32768, -32768, 32767, 32767, 1'b1);
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd1);
    plan_reg(dcsg_pkg::REG_START_X, 16'd0);
    plan_reg(dcsg_pkg::REG_START_Y, 16'd0);
    plan_reg(dcsg_pkg::REG_END_X, 16'd2);
    plan_reg(dcsg_pkg::REG_END_Y, 16'd0);
    plan_pinned(1'b0, 0, 0, 1, -1, 1'b0);
    plan_pinned(1'b0, 1, -1, 2, 0, 1'b1);
    plan_pinned(1'b0, 0, 0, 1, -1, 1'b0);
    // Odd negative sums must halve towards zero, not downwards.
    plan_reg(dcsg_pkg::REG_START_X, 16'hFFFD);
    plan_pinned(1'b1, -3, 0, 0, -2, 1'b0);
    plan_req(1'b0);
    // Fold points leave the coordinate range and wrap.
    plan_reg(dcsg_pkg::REG_START_X, 16'h8000);
    plan_reg(dcsg_pkg::REG_START_Y, 16'h7FFF);
    plan_reg(dcsg_pkg::REG_END_X, 16'h7FFF);
    plan_reg(dcsg_pkg::REG_END_Y, 16'h8000);
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd4);
    plan_req(1'b1);
    plan_req(1'b0);
    plan_req(1'b0);
    // Depths beyond the limit saturate.
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd31);
    plan_req(1'b1);
    plan_req(1'b0);
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd17);
    plan_req(1'b1);
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd16);
    plan_req(1'b1);
    // New end points written part-way through a walk only apply to the next one.
    plan_reg(dcsg_pkg::REG_DEPTH, 16'd2);
    plan_req(1'b1);
    plan_reg(dcsg_pkg::REG_END_X, 16'd1000);
    plan_reg(dcsg_pkg::REG_END_Y, 16'hFC18);
    plan_req(1'b0);
    plan_req(1'b0);
    plan_req(1'b0);
    plan_req(1'b0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_idx, plan[i].value);
      else issue_request(plan[i].restart, plan[i].pinned, plan[i].want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      // Some registers keep their value, so a walk left open from the last phase
      // carries on with the points it latched.
      for (int k = int'(dcsg_pkg::REG_START_X); k <= int'(dcsg_pkg::REG_DEPTH); k++) begin
        if (phase == 0 || $urandom_range(9) < 7) begin
          if (k == int'(dcsg_pkg::REG_DEPTH)) begin
            if (phase == 7) value = 16'd16;
            else if (phase == 11) value = COORD_W'($urandom_range(31, 17));
            else if (phase == 13) value = 16'd0;
            else value = COORD_W'($urandom_range(6, 1));
          end else begin
            case ($urandom_range(7))
              0: value = 16'h8000;
              1: value = 16'h7FFF;
              2: value = 16'h0000;
              3: value = 16'hFFFF;
              default: value = COORD_W'($urandom);
            endcase
          end
          write_reg(dcsg_pkg::cfg_reg_e'(k), value);
        end
      end
      for (int n = 0; n < PHASE_REQS; n++)
        issue_request($urandom_range(99) < 4, 1'b0, '0);
    end

    #1;
    if (req_up) req_if.valid <= 1'b0;
    if (cfg_up) cfg_if.valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Sent %0d requests (%0d restarts) and checked %0d segments;",
             reqs_seen, restarts_seen, segs_seen);
    $display("%0d curves ran to their last segment, %0d mismatches.",
             curves_done, mismatches);
    if (mismatches == 0 && segs_due.size() == 0) begin
      $display("** dragon_curve_segment_generator: PASSED **");
    end else begin
      $display("** dragon_curve_segment_generator: FAILED **");
    end
    $finish;
  end

endmodule
